// File: rtl/rle_byte_decoder_unit_assert.svh
// Assertion shorthands shared by the decoder RTL.
`ifndef RLE_BYTE_DECODER_UNIT_ASSERT_SVH
`define RLE_BYTE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RBD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled in reset.
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int MAX_OUT         = 64;   // most results per input word
  localparam int CODE_W          = 8;
  localparam int HDR_RUN_IDX     = 7;    // header bit 7: repeat packet
  localparam int RUN_BIAS        = 127;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUNVAL,
    PH_LITS,
    PH_SPILL
  } phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    phase_t            phase;
    logic [CODE_W-1:0] pending;
  } hdr_t;

  // Decode a packet header: repeat count (b - 127) or literal count (b + 1).
  function automatic hdr_t take_header(input logic [CODE_W-1:0] b);
    hdr_t h;
    if (b[HDR_RUN_IDX]) begin
      h.phase   = PH_RUNVAL;
      h.pending = b - CODE_W'(RUN_BIAS);
    end else begin
      h.phase   = PH_LITS;
      h.pending = b + CODE_W'(1);
    end
    return h;
  endfunction

endpackage

// File: rtl/rle_byte_decoder_unit.sv
// Byte-wide run-length decoder for Targa-style packet streams.
//
// Input stream (s_*): one compressed byte per word. A header with bit 7 set
// repeats the next byte (header - 127) times; a header with bit 7 clear
// passes the next (header + 1) bytes through. Output stream (m_*): one
// decoded byte per word, tlast on the final word caused by an input word,
// tuser set on the word that completes the configured image length.
// Config channel (cfg_*): image length in bytes, always ready; write it
// only while the decoder is idle. Once the length is reached further input
// words are swallowed without output until the length is raised.
//
// Timing: a header word is taken without output. A data word is accepted,
// then yields one decoded byte per cycle (up to 64) while the receiver
// keeps up; a longer run emits the rest ahead of the next header word. A
// single incrementer with its comparators on the produced-byte count,
// stepped by a small sequencer, paces this; s_tready is low while a word's
// bytes are being produced. Bytes reach m_* via the output register.
// Reset clears the length to zero, the packet state and the byte count;
// the output register empties. A stalled receiver holds the output word
// and freezes the sequencer until m_tready returns.
`include "rle_byte_decoder_unit_assert.svh"

module rle_byte_decoder_unit #(
  parameter int LENGTH_BITS = rbd_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LENGTH_BITS-1:0] cfg_data,   // [LENGTH_BITS-1:0] out_length
  // compressed byte stream in
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,    // [7:0] code_byte
  // decoded byte stream out
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,    // [7:0] pixel_byte
  output logic                   m_tlast,    // last_of_run
  output logic                   m_tuser     // [0] image_done
);
  import rbd_pkg::*;

  localparam int CNT_W = $clog2(MAX_OUT);

  state_t                  state, state_next;
  phase_t                  phase, phase_next;
  logic [CODE_W-1:0]       pending, pending_next;
  logic [LENGTH_BITS-1:0]  produced, produced_next;
  logic [LENGTH_BITS-1:0]  out_length, out_length_next;
  logic [CODE_W-1:0]       run_value, run_value_next;
  logic [CODE_W-1:0]       cur_byte, cur_byte_next;
  logic [CODE_W-1:0]       emit_val, emit_val_next;
  logic [CODE_W-1:0]       emit_left, emit_left_next;
  logic [CNT_W-1:0]        step_cnt, step_cnt_next;
  logic                    out_vld, out_vld_next;
  logic [CODE_W-1:0]       out_data, out_data_next;
  logic                    out_last, out_last_next;
  logic                    out_done, out_done_next;

  // shared count unit
  logic [LENGTH_BITS-1:0]  produced_inc;
  logic                    complete;
  logic                    reach_len;
  logic                    emit_fire;
  logic                    is_last;
  logic [CODE_W-1:0]       left_after;
  hdr_t                    hdr;

  assign produced_inc = produced + LENGTH_BITS'(1);
  assign complete     = (produced >= out_length);
  assign reach_len    = (produced_inc >= out_length);
  assign emit_fire    = (state == ST_EMIT) && (!out_vld || m_tready);
  assign left_after   = emit_left - CODE_W'(1);
  assign is_last      = (emit_left == CODE_W'(1)) ||
                        (step_cnt == CNT_W'(MAX_OUT - 1)) || reach_len;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_vld;
  assign m_tdata   = out_data;
  assign m_tlast   = out_last;
  assign m_tuser   = out_done;

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    pending_next    = pending;
    produced_next   = produced;
    out_length_next = out_length;
    run_value_next  = run_value;
    cur_byte_next   = cur_byte;
    emit_val_next   = emit_val;
    emit_left_next  = emit_left;
    step_cnt_next   = step_cnt;
    out_vld_next    = out_vld;
    out_data_next   = out_data;
    out_last_next   = out_last;
    out_done_next   = out_done;
    hdr             = take_header(s_tdata);

    if (out_vld && m_tready) begin
      out_vld_next = 1'b0;
    end
    if (cfg_valid) begin
      out_length_next = cfg_data;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && !complete) begin
          if (phase == PH_HEADER) begin
            phase_next   = hdr.phase;
            pending_next = hdr.pending;
          end else begin
            cur_byte_next  = s_tdata;
            emit_val_next  = (phase == PH_SPILL) ? run_value : s_tdata;
            emit_left_next = (phase == PH_LITS) ? CODE_W'(1) : pending;
            step_cnt_next  = '0;
            state_next     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_vld_next   = 1'b1;
          out_data_next  = emit_val;
          out_last_next  = is_last;
          out_done_next  = (produced_inc == out_length);
          produced_next  = produced_inc;
          emit_left_next = left_after;
          step_cnt_next  = step_cnt + CNT_W'(1);
          if (is_last) begin
            state_next = ST_IDLE;
            unique case (phase)
              PH_HEADER: begin
              end
              PH_RUNVAL: begin
                // run cut by the per-word limit spills into the next word
                if (left_after != '0 && !reach_len) begin
                  pending_next   = left_after;
                  run_value_next = cur_byte;
                  phase_next     = PH_SPILL;
                end else begin
                  pending_next = '0;
                  phase_next   = PH_HEADER;
                end
              end
              PH_LITS: begin
                pending_next = pending - CODE_W'(1);
                if (pending == CODE_W'(1)) begin
                  phase_next = PH_HEADER;
                end
              end
              PH_SPILL: begin
                // the word that carried the spill is the next header
                hdr          = take_header(cur_byte);
                phase_next   = hdr.phase;
                pending_next = hdr.pending;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_HEADER;
      pending    <= '0;
      produced   <= '0;
      out_length <= '0;
      run_value  <= '0;
      out_vld    <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      pending    <= pending_next;
      produced   <= produced_next;
      out_length <= out_length_next;
      run_value  <= run_value_next;
      out_vld    <= out_vld_next;
    end
    cur_byte  <= cur_byte_next;
    emit_val  <= emit_val_next;
    emit_left <= emit_left_next;
    step_cnt  <= step_cnt_next;
    out_data  <= out_data_next;
    out_last  <= out_last_next;
    out_done  <= out_done_next;
  end

  `RBD_ASSERT_IMPL(a_emit_left_nonzero, clk, rst, state == ST_EMIT, emit_left != '0)
  `RBD_ASSERT_IMPL(a_done_is_last, clk, rst, out_vld && out_done, out_last)
  `RBD_ASSERT_IMPL(a_spill_bounded, clk, rst, phase == PH_SPILL,
                   pending != '0 && pending <= CODE_W'(MAX_OUT))
  `RBD_ASSERT_NEXT(a_last_to_idle, clk, rst, emit_fire && is_last, state == ST_IDLE)

endmodule

// File: verif/tb_top.sv
module tb_top;
  import rbd_pkg::*;

  localparam int LW            = LENGTH_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;     // a header word may still be in flight
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all

  // Directed rows: a code word, or a new image length.
  typedef enum {
    ROW_CODE,
    ROW_LEN
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [LW-1:0] val;
    bit            typed;   // result below is known up front
    int            nres;    // pixel words caused by this code word
    logic [7:0]    pix;     // value of the last of them
    bit            done;    // image_done on the last of them
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       lst;
    logic       dn;
  } pixel_word_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [LW-1:0] cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [7:0]    m_tdata;
  logic          m_tlast;
  logic          m_tuser;

  always #5 clk = ~clk;

  rle_byte_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // ---------------------------------------------------------------------
  // Decoder prediction: own copy of the packet state and image length.
  // ---------------------------------------------------------------------
  pixel_word_t   pixq[$];     // decoded bytes still owed by the DUT
  logic [LW-1:0] img_len   = '0;
  logic [LW-1:0] img_count = '0;
  phase_t        dec_ph    = PH_HEADER;
  logic [7:0]    to_go     = '0;

  int          word_nres;     // results of the code word just decoded
  pixel_word_t word_tail;
  int          n_words, n_live, n_swallowed, n_checked, n_lens, n_errs;
  bit          src_calm, sink_calm;

  task automatic take_hdr(input logic [7:0] b);
    if (b[HDR_RUN_IDX]) begin
      to_go  = b - 8'(RUN_BIAS);
      dec_ph = PH_RUNVAL;
    end else begin
      to_go  = b + 8'd1;
      dec_ph = PH_LITS;
    end
  endtask

  task automatic put_pixel(input logic [7:0] v);
    pixel_word_t w;
    img_count = img_count + 1'b1;
    w.pix = v;
    w.lst = 1'b0;
    w.dn  = (img_count == img_len);
    pixq.push_back(w);
  endtask

  // Up to cnt copies, capped per code word and at the image end.
  task automatic put_run(input logic [7:0] v, input int cnt, output int made);
    made = 0;
    while (made < cnt && made < MAX_OUT && img_count < img_len) begin
      put_pixel(v);
      made++;
    end
  endtask

  task automatic close_word(input int made);
    if (made > 0) begin
      pixq[pixq.size()-1].lst = 1'b1;
      word_nres += made;
    end
  endtask

  // A run longer than MAX_OUT finishes ahead of the next header word; its
  // rest does not depend on that word, so it is queued right away. The
  // header that follows is then taken even if the rest completed the image.
  task automatic decode_code(input logic [7:0] b);
    int made;
    word_nres = 0;
    if (dec_ph != PH_SPILL && img_count >= img_len) begin
      n_swallowed++;
      return;
    end
    n_live++;
    case (dec_ph)
      PH_HEADER, PH_SPILL: take_hdr(b);
      PH_RUNVAL: begin
        put_run(b, int'(to_go), made);
        close_word(made);
        if (made < int'(to_go) && img_count < img_len) begin
          to_go = to_go - 8'(made);
          put_run(b, int'(to_go), made);
          close_word(made);
          dec_ph = PH_SPILL;
        end else begin
          dec_ph = PH_HEADER;
        end
        to_go = '0;
      end
      PH_LITS: begin
        put_pixel(b);
        close_word(1);
        to_go = to_go - 8'd1;
        if (to_go == 0) dec_ph = PH_HEADER;
      end
    endcase
    if (word_nres != 0) word_tail = pixq[$];
  endtask

  // ---------------------------------------------------------------------
  // Drivers. Sender gap is drawn per word; valid stays up across words
  // when the gap is zero.
  // ---------------------------------------------------------------------
  task automatic send_code(input logic [7:0] b);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_words++;
    decode_code(b);
  endtask

  // Let every owed byte come out. A pending run rest may need the next
  // header word before it shows, so one is sent first.
  task automatic drain_all();
    if (dec_ph == PH_SPILL) send_code(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;
    while (pixq.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LW-1:0] v);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    img_len = v;
    n_lens++;
  endtask

  // One packet with random content; now and then a stray word that
  // knocks the stream out of step.
  task automatic send_packet();
    int sel;
    logic [7:0] hdr;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      send_code(8'($urandom_range(0, 255)));
    end else if (sel < 5) begin
      hdr = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                        : 8'($urandom_range(128, 135));
      send_code(hdr);
      send_code(8'($urandom_range(0, 255)));
    end else begin
      hdr = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 127))
                                         : 8'($urandom_range(0, 5));
      send_code(hdr);
      repeat (int'(hdr) + 1) send_code(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: after each word taken, hold m_tready low for a drawn stall.
  // ---------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin : sink
    int d;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
    end else if (m_tvalid) begin
      d = sink_calm ? 0 : $urandom_range(0, 19);
      if (d != 0) begin
        m_tready   <= 1'b0;
        stall_left <= d - 1;
      end
    end
  end

  // Each pixel word against the oldest owed one.
  always @(posedge clk) begin : check_pixel
    pixel_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_checked++;
      if (pixq.size() == 0) begin
        $error("pixel word %0h with nothing owed", m_tdata);
        n_errs++;
      end else begin
        want = pixq.pop_front();
        if (m_tdata !== want.pix) begin
          $error("pixel_byte: expected %0h, got %0h", want.pix, m_tdata);
          n_errs++;
        end
        if (m_tlast !== want.lst) begin
          $error("last_of_run: expected %0b, got %0b", want.lst, m_tlast);
          n_errs++;
        end
        if (m_tuser !== want.dn) begin
          $error("image_done: expected %0b, got %0b", want.dn, m_tuser);
          n_errs++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("rle_byte_decoder_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Directed table: zero length, full-range length, one-byte and 128-byte
  // runs, a run of 65 that spills one byte, literals, a finished image
  // swallowing words, a length raise resuming with a cut-short run.
  // Produced count before the raise to 203 is 197.
  // ---------------------------------------------------------------------
  stim_row_t dir_rows [25] = '{
    '{ROW_CODE, 24'h85,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h42,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_LEN,  24'hFFFFFF, 1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h80,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'hFF,     1'b1, 1,   8'hFF, 1'b0},
    '{ROW_CODE, 24'hFF,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h00,     1'b1, 128, 8'h00, 1'b0},
    '{ROW_CODE, 24'h01,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'hAA,     1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h55,     1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'hC0,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h5A,     1'b1, 65,  8'h5A, 1'b0},
    '{ROW_CODE, 24'h00,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h80,     1'b1, 1,   8'h80, 1'b0},
    '{ROW_LEN,  24'd5,      1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h83,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_LEN,  24'd203,    1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h83,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h11,     1'b1, 4,   8'h11, 1'b0},
    '{ROW_CODE, 24'h84,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h22,     1'b1, 2,   8'h22, 1'b1},
    '{ROW_CODE, 24'h00,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_LEN,  24'd0,      1'b0, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h7F,     1'b1, 0,   8'h00, 1'b0},
    '{ROW_CODE, 24'h9C,     1'b1, 0,   8'h00, 1'b0}
  };

  initial begin : stimulus
    int live0, swal0;
    bit paused;
    logic [LW-1:0] len;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_calm  = 1'b0;
    sink_calm = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) begin
        set_length(dir_rows[i].val);
      end else begin
        send_code(dir_rows[i].val[7:0]);
        if (dir_rows[i].typed) begin
          if (word_nres != dir_rows[i].nres) begin
            $error("row %0d: expected %0d pixel words, predicted %0d",
                   i, dir_rows[i].nres, word_nres);
            n_errs++;
          end else if (word_nres != 0 &&
                       (word_tail.pix !== dir_rows[i].pix ||
                        word_tail.dn !== dir_rows[i].done)) begin
            $error("row %0d: expected last word %0h/%0b, predicted %0h/%0b", i,
                   dir_rows[i].pix, dir_rows[i].done, word_tail.pix, word_tail.dn);
            n_errs++;
          end
        end
      end
    end

    // Random phases: roomy length, short length that fills and then
    // swallows words, roomy again with a full pause, then the maximum.
    paused = 1'b0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0, 2:    len = img_count + LW'($urandom_range(100, 400));
        1:       len = img_count + LW'($urandom_range(10, 40));
        default: len = {LW{1'b1}};
      endcase
      set_length(len);
      src_calm  = (p == 0) || ($urandom_range(0, 3) == 0);
      sink_calm = (p == 0) || ($urandom_range(0, 3) == 0);
      live0 = n_live;
      swal0 = n_swallowed;
      while (n_live - live0 < 56 && n_swallowed - swal0 < 6) begin
        send_packet();
        if (p == 2 && !paused && n_live - live0 >= 24) begin
          drain_all();
          paused = 1'b1;
        end
      end
    end

    drain_all();

    $display("%0d code words sent, %0d swallowed past the image end; %0d pixel words checked",
             n_words, n_swallowed, n_checked);
    $display("%0d image lengths used, from zero to the 24-bit maximum", n_lens);
    if (n_errs == 0) begin
      $display("rle_byte_decoder_unit test passed");
    end else begin
      $display("rle_byte_decoder_unit test failed");
    end
    $finish;
  end

endmodule
